### rtl/core/pccl_pkg.sv
// Shared constants, widths and the sequencer state type for the pixel
// circle chord length core. No dependencies.
`timescale 1ns / 1ps

package pccl_pkg;

  localparam int MAX_DIAMETER = 64;
  localparam int HALF_DEPTH   = MAX_DIAMETER / 2 + 1;

  localparam int DIAM_W   = 7;
  localparam int CHORD_W  = 7;
  localparam int INDENT_W = 6;
  localparam int AREA_W   = 13;
  localparam int PROD_W   = 13;
  localparam int ADDR_W   = $clog2(HALF_DEPTH);
  localparam int ROW_W    = $clog2(MAX_DIAMETER);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INNER_CHECK,
    ST_INNER_DROP,
    ST_OUTER_START,
    ST_OUTER_RD,
    ST_OUTER_CMP,
    ST_EMIT,
    ST_EMIT_LOAD
  } phase_t;

endpackage

### rtl/core/pccl_if.sv
// Valid/ready channel interfaces for the diameter requests and the row items.
// Depends on pccl_pkg for the field widths.
`timescale 1ns / 1ps

interface pccl_diam_if import pccl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DIAM_W-1:0] diameter;

  modport source (output valid, output diameter, input ready);
  modport sink   (input valid, input diameter, output ready);
endinterface

interface pccl_row_if import pccl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CHORD_W-1:0]  chord_length;
  logic [INDENT_W-1:0] indent;
  logic                last_row;
  logic [AREA_W-1:0]   area;

  modport source (output valid, output chord_length, output indent, output last_row,
                  output area, input ready);
  modport sink   (input valid, input chord_length, input indent, input last_row,
                  input area, output ready);
endinterface

### rtl/core/pccl_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module pccl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/pixel_circle_chord_lengths_core.sv
// Top level of the pixel circle chord length core: sequencer, arithmetic and
// output register. Depends on pccl_pkg, pccl_if and pccl_ram.
`timescale 1ns / 1ps
//
// Usage
// -----
// A diameter item (1 to 64) arrives on the req channel; the block answers with
// one row item per pixel row on the row channel, top row first. Each row item
// carries the chord length, the indent (diameter minus chord, halved), a last
// flag on the final row, and the total disc area on that final row only.
// A diameter of zero or above 64 is taken and dropped without any row item.
//
// The chords of the upper half live in a 33-entry RAM with a registered read.
// Each inner row takes a check step and a drop step, the drop step repeating per
// chord reduction; each outer row takes a start step plus a RAM read and a
// compare per stored chord it counts. Rows then leave one at a time, each being
// one RAM read of the mirrored entry, and each waits while the output register
// is full; req.ready is high only while the sequencer is idle.
//
// Reset (synchronous, active high) returns the sequencer to idle and empties
// the output register; the RAM needs no clearing since every entry read has
// been written earlier in the same request. A stalled receiver holds the
// current row item; the next RAM read waits until the register is free, and
// the final row may still wait there while the next diameter is accepted.

module pixel_circle_chord_lengths_core import pccl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  pccl_diam_if.sink   req,
  pccl_row_if.source  row
);

  phase_t state, state_next;

  // Request context and loop counters.
  logic [DIAM_W-1:0]  diam;
  logic [ADDR_W-1:0]  cnt;     // entries written so far
  logic [ADDR_W-1:0]  c_inner; // inner rows built
  logic [ADDR_W-1:0]  b;       // chord being counted in an outer row
  logic [ROW_W-1:0]   k;       // row being emitted
  logic [CHORD_W-1:0] prev;    // most recent chord written
  logic [CHORD_W-1:0] lb;      // chord under reduction
  logic [CHORD_W-1:0] vsum;    // outer-row chord being counted up
  logic [PROD_W-1:0]  prod;    // circle product of the current inner row
  logic [AREA_W-1:0]  area;

  // Output register.
  logic                out_valid;
  logic [CHORD_W-1:0]  out_chord;
  logic [INDENT_W-1:0] out_indent;
  logic                out_last;
  logic [AREA_W-1:0]   out_area;

  // RAM ports.
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [CHORD_W-1:0] ram_wdata;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [CHORD_W-1:0] ram_rdata;

  pccl_ram #(
    .WIDTH (CHORD_W),
    .DEPTH (HALF_DEPTH)
  ) u_half_chords (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Geometry of the current diameter and the request handshake.
  logic                odd;
  logic [ADDR_W-1:0]   g;
  logic [1:0]          zz;
  logic [ADDR_W-1:0]   b_limit;
  logic                req_accept;
  logic                diam_ok;

  assign odd        = diam[0];
  assign g          = ADDR_W'(diam[DIAM_W-1:1]) + ADDR_W'(odd);
  assign zz         = odd ? 2'd2 : 2'd1;
  assign b_limit    = c_inner - ADDR_W'(odd);
  assign req.ready  = (state == ST_IDLE);
  assign req_accept = req.valid && req.ready;
  assign diam_ok    = (req.diameter != '0) && (req.diameter <= DIAM_W'(MAX_DIAMETER));

  // An inner row is built while 2*cnt - zz + 1 < 2*(prev div 2).
  logic [7:0]  inner_lhs, inner_rhs;
  logic        inner_go;
  logic [7:0]  prod_a;
  logic [7:0]  prod_b;
  logic [15:0] prod_full;

  assign inner_lhs = {1'b0, cnt, 1'b0} + 8'd1;
  assign inner_rhs = {1'b0, prev[CHORD_W-1:1], 1'b0} + {6'd0, zz};
  assign inner_go  = (cnt < ADDR_W'(HALF_DEPTH)) && (inner_lhs < inner_rhs);
  // (d + 2n - zz) and (d - 2n + zz) with n = cnt + 1; the second is
  // non-negative whenever inner_go holds.
  assign prod_a    = {1'b0, diam} + {1'b0, cnt, 1'b0} + 8'd2 - {6'd0, zz};
  assign prod_b    = {1'b0, diam} + {6'd0, zz} - {1'b0, cnt, 1'b0} - 8'd2;
  assign prod_full = prod_a * prod_b;

  // Chord reduction: drop by two while the product is below (2*(lb div 2) - 1)^2.
  logic             lb_ge2;
  logic [5:0]       t_val;
  logic [11:0]      t_sq;
  logic             drop;

  assign lb_ge2 = (lb[CHORD_W-1:1] != '0);
  assign t_val  = 6'({lb[CHORD_W-1:1], 1'b0} - 7'd1);
  assign t_sq   = t_val * t_val;
  assign drop   = lb_ge2 && (prod < {1'b0, t_sq});

  // Outer rows count stored chords with chord + odd >= 2 + 2*cnt.
  logic [7:0]         thr;
  logic               hit;
  logic [CHORD_W-1:0] vsum_new;
  logic [ADDR_W-1:0]  b_inc;

  assign thr      = {1'b0, cnt, 1'b0} + 8'd2;
  assign hit      = ({1'b0, ram_rdata} + {7'd0, odd}) >= thr;
  assign vsum_new = vsum + (hit ? CHORD_W'(2) : CHORD_W'(0));
  assign b_inc    = b + ADDR_W'(1);

  // Mirrored index of the emitted row.
  logic [ADDR_W-1:0]   idx;
  logic                out_free;
  logic                row_last;
  logic [DIAM_W-1:0]   indent_diff;

  assign idx = ({1'b0, k} < {1'b0, g}) ? ADDR_W'(g - ADDR_W'(1) - ADDR_W'(k))
                                       : ADDR_W'(ADDR_W'(k) - g + ADDR_W'(odd));
  assign out_free    = !out_valid || row.ready;
  assign row_last    = ({1'b0, k} == (diam - DIAM_W'(1)));
  assign indent_diff = (diam >= ram_rdata) ? (diam - ram_rdata) : '0;

  // Next state and RAM control.
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = cnt;
    ram_wdata  = '0;
    ram_raddr  = idx;
    unique case (state)
      ST_IDLE: begin
        if (req_accept && diam_ok) begin
          ram_we     = 1'b1;
          ram_waddr  = '0;
          ram_wdata  = req.diameter;
          state_next = ST_INNER_CHECK;
        end
      end
      ST_INNER_CHECK: begin
        state_next = inner_go ? ST_INNER_DROP : ST_OUTER_START;
      end
      ST_INNER_DROP: begin
        if (!drop) begin
          ram_we     = 1'b1;
          ram_wdata  = lb;
          state_next = ST_INNER_CHECK;
        end
      end
      ST_OUTER_START: begin
        if (cnt < g) begin
          if (b_limit == '0) begin
            // No stored chord to count: the row is just the centre pixel.
            ram_we    = 1'b1;
            ram_wdata = CHORD_W'(odd);
          end else begin
            state_next = ST_OUTER_RD;
          end
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_OUTER_RD: begin
        ram_raddr  = b + ADDR_W'(odd);
        state_next = ST_OUTER_CMP;
      end
      ST_OUTER_CMP: begin
        if (b_inc == b_limit) begin
          ram_we     = 1'b1;
          ram_wdata  = vsum_new;
          state_next = ST_OUTER_START;
        end else begin
          state_next = ST_OUTER_RD;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_EMIT_LOAD;
        end
      end
      ST_EMIT_LOAD: begin
        state_next = row_last ? ST_IDLE : ST_EMIT;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req_accept && diam_ok) begin
      diam <= req.diameter;
      cnt  <= ADDR_W'(1);
      prev <= req.diameter;
      area <= AREA_W'({req.diameter, 1'b0});
    end else if (ram_we) begin
      cnt  <= cnt + ADDR_W'(1);
      prev <= ram_wdata;
      area <= area + AREA_W'({ram_wdata, 1'b0});
    end else if (state == ST_OUTER_START && !(cnt < g)) begin
      // The centre row of an odd disc was counted twice above.
      area <= area - (odd ? AREA_W'(diam) : AREA_W'(0));
    end

    if (state == ST_INNER_CHECK) begin
      lb <= prev;
      if (inner_go) begin
        prod <= prod_full[PROD_W-1:0];
      end else begin
        c_inner <= cnt;
      end
    end else if (state == ST_INNER_DROP && drop) begin
      lb <= lb - CHORD_W'(2);
    end

    if (state == ST_OUTER_START) begin
      vsum <= CHORD_W'(odd);
      b    <= '0;
      k    <= '0;
    end else if (state == ST_OUTER_CMP) begin
      vsum <= vsum_new;
      b    <= b_inc;
    end else if (state == ST_EMIT_LOAD) begin
      k <= k + ROW_W'(1);
    end

    if (state == ST_EMIT_LOAD) begin
      out_chord  <= ram_rdata;
      out_indent <= indent_diff[DIAM_W-1:1];
      out_last   <= row_last;
      out_area   <= row_last ? area : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMIT_LOAD) begin
      out_valid <= 1'b1;
    end else if (row.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign row.valid        = out_valid;
  assign row.chord_length = out_chord;
  assign row.indent       = out_indent;
  assign row.last_row     = out_last;
  assign row.area         = out_area;

  // Checks on the sequencer and the output register.
  a_area_only_last: assert property (@(posedge clk) disable iff (rst)
    row.valid && !row.last_row |-> row.area == '0)
    else $error("area reported on a row that is not the last");

  a_load_into_free: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT_LOAD |-> !out_valid)
    else $error("row loaded while the output register is still full");

  a_emit_reads_written: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> idx < cnt)
    else $error("row read from a chord entry not written by this request");

  a_cnt_in_range: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> cnt <= ADDR_W'(HALF_DEPTH))
    else $error("chord entry count beyond the store depth");

endmodule

### verif/pccl_disc_checker.sv
// Checker for the pixel circle chord length core: predicts the row items of
// each accepted diameter and compares them with the row channel.
// Depends on pccl_pkg and the channel interfaces in pccl_if.
`timescale 1ns / 1ps

module pccl_disc_checker import pccl_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  pccl_diam_if  req,
  pccl_row_if   row,
  output int    rows_pending,
  output int    fail_count
);

  typedef struct packed {
    logic [CHORD_W-1:0]  chord;
    logic [INDENT_W-1:0] indent;
    logic                last;
    logic [AREA_W-1:0]   area;
  } disc_row_t;

  disc_row_t row_q[$];
  int        upper_chords [HALF_DEPTH];
  int        rows_checked;

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= 40) $display("%0t ns: %s", $time, msg);
  endtask

  // Adds one expected item at the tail of the queue.
  function automatic void queue_expected(input disc_row_t r);
    row_q.insert(row_q.size(), r);
  endfunction

  // Builds the upper half chords from the centre row outward, mirrors them
  // and queues one expected item per row, top row first.
  function automatic void build_disc_rows(input int d);
    int odd, zz, ups, cnt, inner, prev, h, n, prod, lb, t, v, total, idx, ch, ind;
    int a, b, k;
    disc_row_t r;
    if (d < 1 || d > MAX_DIAMETER) return;
    odd = d & 1;
    zz  = odd ? 2 : 1;
    ups = (d >> 1) + odd;
    upper_chords[0] = d;
    cnt = 1;
    // Inner rows: start from the chord above and shrink in steps of two while
    // the circle product in half units falls below the squared half chord.
    while (cnt < HALF_DEPTH) begin
      prev = upper_chords[cnt - 1];
      h    = prev / 2;
      if (!(2 * cnt - zz + 1 < 2 * h)) break;
      n    = cnt + 1;
      prod = (d + 2 * n - zz) * (d - 2 * n + zz);
      lb   = prev;
      while (lb >= 2) begin
        t = 2 * (lb / 2) - 1;
        if (prod < t * t) lb -= 2;
        else break;
      end
      upper_chords[cnt] = lb & 8'h7f;
      cnt++;
    end
    inner = cnt;
    // Outer rows: count the inner chords that reach past a column threshold.
    for (a = 0; a < ups - inner && cnt < HALF_DEPTH; a++) begin
      v = odd;
      for (b = 0; b < inner - odd; b++) begin
        if (upper_chords[b + odd] - 2 * inner + odd - 2 * a >= 2) v += 2;
      end
      upper_chords[cnt] = v & 8'h7f;
      cnt++;
    end
    total = 0;
    for (k = 0; k < cnt; k++) total += 2 * upper_chords[k];
    total -= odd * d;
    for (k = 0; k < d; k++) begin
      idx = (k < ups) ? (ups - 1 - k) : (k - ups + odd);
      if (idx < 0) idx = 0;
      if (idx >= HALF_DEPTH) idx = HALF_DEPTH - 1;
      ch  = upper_chords[idx];
      ind = (d >= ch) ? (d - ch) / 2 : 0;
      r.chord  = CHORD_W'(ch);
      r.indent = INDENT_W'(ind);
      r.last   = (k == d - 1);
      r.area   = (k == d - 1) ? AREA_W'(total) : '0;
      queue_expected(r);
    end
  endfunction

  always @(posedge clk) begin : watch
    disc_row_t want;
    if (rst) begin
      row_q.delete();
    end else begin
      if (row.valid && row.ready) begin
        if (row_q.size() == 0) begin
          report_mismatch($sformatf("row item with none expected: chord %0d", row.chord_length));
        end else begin
          want = row_q.pop_front();
          if (row.chord_length !== want.chord)
            report_mismatch($sformatf("row %0d chord_length %0d, expected %0d",
                                      rows_checked, row.chord_length, want.chord));
          if (row.indent !== want.indent)
            report_mismatch($sformatf("row %0d indent %0d, expected %0d",
                                      rows_checked, row.indent, want.indent));
          if (row.last_row !== want.last)
            report_mismatch($sformatf("row %0d last_row %0b, expected %0b",
                                      rows_checked, row.last_row, want.last));
          if (row.area !== want.area)
            report_mismatch($sformatf("row %0d area %0d, expected %0d",
                                      rows_checked, row.area, want.area));
          rows_checked++;
        end
      end
      if (req.valid && req.ready) build_disc_rows(int'(req.diameter));
    end
    rows_pending = row_q.size();
  end

endmodule

### verif/tb_top.sv
// Top of the testbench for the pixel circle chord length core: clock, reset,
// diameter stimulus, receiver stalls and the final verdict.
// Depends on pccl_pkg, pccl_if, the core and pccl_disc_checker.
`timescale 1ns / 1ps

module tb_top;
  import pccl_pkg::*;

  // With the largest disc and every row stalled as long as the receiver allows,
  // about 220 diameters at that worst rate still sit well inside this limit.
  localparam int LIMIT_CYCLES = 1_500_000;
  // Cycles left to run once nothing is expected, enough for a whole request.
  localparam int DRAIN_CYCLES = 700;
  localparam int RANDOM_ITEMS = 200;

  logic clk = 1'b0;
  logic rst;
  int   rows_pending;
  int   fail_count;
  int   cycle_count;
  int   send_gap_pct;
  int   stall_pct;
  int   stall_left;

  // Edge cases first: the smallest discs, the largest, an odd and even pair
  // around each power of two, and the diameters the block must drop (zero,
  // just above the maximum, the all-ones code, and 96).
  int directed_diams [20] = '{1, 2, 3, 4, 5, 6, 64, 63, 0, 65, 127, 62, 33, 32, 31,
                              16, 17, 9, 10, 96};

  always #10 clk = ~clk;

  pccl_diam_if req_ch ();
  pccl_row_if  row_ch ();

  pixel_circle_chord_lengths_core uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .row (row_ch)
  );

  pccl_disc_checker chk (
    .clk          (clk),
    .rst          (rst),
    .req          (req_ch),
    .row          (row_ch),
    .rows_pending (rows_pending),
    .fail_count   (fail_count)
  );

  // Watchdog: a hung block or a lost row item ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // Receiver: ready drops in bursts of random length. A burst starts with
  // the chance given by stall_pct, so the stalls land on the inner, outer and
  // emit phases of the block alike.
  always @(posedge clk) begin
    if (rst) begin
      stall_left   <= 0;
      row_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      row_ch.ready <= 1'b0;
    end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
      stall_left   <= $urandom_range(0, 9);
      row_ch.ready <= 1'b0;
    end else begin
      row_ch.ready <= 1'b1;
    end
  end

  // Offers one diameter and holds it until the block takes it. Valid stays
  // high into the next item unless a gap is drawn, in which case the bus
  // carries random noise while valid is low.
  task automatic send_diameter(input int d);
    req_ch.valid    <= 1'b1;
    req_ch.diameter <= DIAM_W'(d);
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    if (send_gap_pct > 0 && $urandom_range(0, 99) < send_gap_pct) begin
      req_ch.valid    <= 1'b0;
      req_ch.diameter <= DIAM_W'($urandom);
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  initial begin
    int sent;
    int pick;
    int d;
    rst             <= 1'b1;
    req_ch.valid    <= 1'b0;
    req_ch.diameter <= '0;
    send_gap_pct    = 20;
    stall_pct       = 20;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_diams[i]) send_diameter(directed_diams[i]);

    // Random part. Only diameters from 1 to 64 count towards the total; the
    // odd dropped diameter is mixed in as noise. The idling changes by phase,
    // with a quiet stretch in the middle and none at all towards the end.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent < 60) begin
        send_gap_pct = 25;
        stall_pct    = 25;
      end else if (sent < 120) begin
        send_gap_pct = 60;
        stall_pct    = 50;
      end else if (sent < 140) begin
        send_gap_pct = 0;
        stall_pct    = 0;
      end else if (sent < 175) begin
        send_gap_pct = 10;
        stall_pct    = 70;
      end else begin
        send_gap_pct = 0;
        stall_pct    = 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        d = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(MAX_DIAMETER + 1, 127);
      end else begin
        if (pick < 30) d = $urandom_range(1, 8);
        else if (pick < 42) d = $urandom_range(56, MAX_DIAMETER);
        else d = $urandom_range(1, MAX_DIAMETER);
        sent++;
      end
      send_diameter(d);
    end
    req_ch.valid <= 1'b0;

    // Give the checker a moment to queue the last request, wait for every
    // expected row, then let a further request's worth of cycles pass so
    // that any stray row item is caught.
    repeat (2) @(posedge clk);
    while (rows_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/pccl_pkg.sv
rtl/core/pccl_if.sv
rtl/core/pccl_ram.sv
rtl/core/pixel_circle_chord_lengths_core.sv
verif/pccl_disc_checker.sv
verif/tb_top.sv
